>>> rtl/core/sdiv_pkg.sv
// Shared types and constants for the signed 64-by-32 saturating divider.
// Used by every module and interface under rtl/core; depends on nothing.
package sdiv_pkg;

  localparam int DVD_W = 64;  // dividend width
  localparam int DVS_W = 32;  // divisor width and magnitude width
  localparam int QUO_W = 32;  // quotient port width
  localparam int STS_W = 2;   // status code width

  typedef enum logic [STS_W-1:0] {
    ST_OK   = 2'd0,
    ST_OVF  = 2'd1,
    ST_DIV0 = 2'd2
  } status_t;

  // Control that travels down the pipeline beside the data.
  typedef struct packed {
    logic    qneg;
    status_t status;
  } ctrl_t;

endpackage

>>> rtl/core/sdiv_in_if.sv
// Input channel of the divider: valid/ready handshake plus operands.
// Depends on sdiv_pkg for the field widths.
interface sdiv_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [sdiv_pkg::DVD_W-1:0]  dividend;
  logic signed [sdiv_pkg::DVS_W-1:0]  divisor;

  modport source (output valid, dividend, divisor, input ready);
  modport sink   (input valid, dividend, divisor, output ready);
endinterface

>>> rtl/core/sdiv_out_if.sv
// Result channel of the divider: valid/ready handshake plus quotient and status.
// Depends on sdiv_pkg for the field widths.
interface sdiv_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [sdiv_pkg::QUO_W-1:0]  quotient;
  logic        [sdiv_pkg::STS_W-1:0]  status;

  modport source (output valid, quotient, status, input ready);
  modport sink   (input valid, quotient, status, output ready);
endinterface

>>> rtl/core/sdiv_prep.sv
// Front stage: operand magnitudes, quotient sign and divide-by-zero flag.
// Depends on sdiv_pkg.
module sdiv_prep (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              vld_i,
  output logic                              rdy_o,
  input  logic signed [sdiv_pkg::DVD_W-1:0] dividend_i,
  input  logic signed [sdiv_pkg::DVS_W-1:0] divisor_i,
  output logic                              vld_o,
  input  logic                              rdy_i,
  output logic [sdiv_pkg::DVD_W-1:0]        nx_o,
  output logic [sdiv_pkg::DVS_W-1:0]        dy_o,
  output sdiv_pkg::ctrl_t                   ctrl_o
);

  logic                        vld_r;
  logic [sdiv_pkg::DVD_W-1:0]  nx_r, nx_nxt;
  logic [sdiv_pkg::DVS_W-1:0]  dy_r, dy_nxt;
  sdiv_pkg::ctrl_t             ctrl_r, ctrl_nxt;
  logic                        xneg, yneg;

  assign rdy_o = !vld_r || rdy_i;

  always_comb begin
    xneg = dividend_i[sdiv_pkg::DVD_W-1];
    yneg = divisor_i[sdiv_pkg::DVS_W-1];
    // Two's complement negate gives the exact magnitude, most negative included.
    nx_nxt = xneg ? (~dividend_i + 1'b1) : dividend_i;
    dy_nxt = yneg ? (~divisor_i + 1'b1) : divisor_i;
    ctrl_nxt.qneg   = xneg ^ yneg;
    ctrl_nxt.status = (divisor_i == '0) ? sdiv_pkg::ST_DIV0 : sdiv_pkg::ST_OK;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (rdy_o) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (vld_i && rdy_o) begin
      nx_r   <= nx_nxt;
      dy_r   <= dy_nxt;
      ctrl_r <= ctrl_nxt;
    end
  end

  assign vld_o  = vld_r;
  assign nx_o   = nx_r;
  assign dy_o   = dy_r;
  assign ctrl_o = ctrl_r;

endmodule

>>> rtl/core/sdiv_chk.sv
// Overflow check stage: flags quotients whose magnitude does not fit Q_W bits
// and narrows the dividend magnitude to the remainder width. Depends on sdiv_pkg.
module sdiv_chk #(
  parameter int Q_W   = 31,
  parameter int REM_W = 62
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        vld_i,
  output logic                        rdy_o,
  input  logic [sdiv_pkg::DVD_W-1:0]  nx_i,
  input  logic [sdiv_pkg::DVS_W-1:0]  dy_i,
  input  sdiv_pkg::ctrl_t             ctrl_i,
  output logic                        vld_o,
  input  logic                        rdy_i,
  output logic [REM_W-1:0]            rem_o,
  output logic [sdiv_pkg::DVS_W-1:0]  dy_o,
  output sdiv_pkg::ctrl_t             ctrl_o
);

  localparam int CW = sdiv_pkg::DVD_W - Q_W;

  logic                        vld_r;
  logic [REM_W-1:0]            rem_r;
  logic [sdiv_pkg::DVS_W-1:0]  dy_r;
  sdiv_pkg::ctrl_t             ctrl_r, ctrl_nxt;
  logic                        ovf;

  assign rdy_o = !vld_r || rdy_i;

  // nx >= dy << Q_W is the same as the upper bits of nx against dy.
  assign ovf = nx_i[sdiv_pkg::DVD_W-1:Q_W] >= {{(CW-sdiv_pkg::DVS_W){1'b0}}, dy_i};

  always_comb begin
    ctrl_nxt = ctrl_i;
    // Divide by zero wins over overflow.
    if (ctrl_i.status == sdiv_pkg::ST_OK && ovf) begin
      ctrl_nxt.status = sdiv_pkg::ST_OVF;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (rdy_o) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (vld_i && rdy_o) begin
      rem_r  <= nx_i[REM_W-1:0];
      dy_r   <= dy_i;
      ctrl_r <= ctrl_nxt;
    end
  end

  assign vld_o  = vld_r;
  assign rem_o  = rem_r;
  assign dy_o   = dy_r;
  assign ctrl_o = ctrl_r;

endmodule

>>> rtl/core/sdiv_step.sv
// One restoring division step as a register stage: decides quotient bit BIT.
// Depends on sdiv_pkg.
module sdiv_step #(
  parameter int Q_W   = 31,
  parameter int REM_W = 62,
  parameter int BIT   = 0
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        vld_i,
  output logic                        rdy_o,
  input  logic [REM_W-1:0]            rem_i,
  input  logic [Q_W-1:0]              q_i,
  input  logic [sdiv_pkg::DVS_W-1:0]  dy_i,
  input  sdiv_pkg::ctrl_t             ctrl_i,
  output logic                        vld_o,
  input  logic                        rdy_i,
  output logic [REM_W-1:0]            rem_o,
  output logic [Q_W-1:0]              q_o,
  output logic [sdiv_pkg::DVS_W-1:0]  dy_o,
  output sdiv_pkg::ctrl_t             ctrl_o
);

  localparam int HW = REM_W - BIT;

  logic                        vld_r;
  logic [REM_W-1:0]            rem_r, rem_nxt;
  logic [Q_W-1:0]              q_r, q_nxt;
  logic [sdiv_pkg::DVS_W-1:0]  dy_r;
  sdiv_pkg::ctrl_t             ctrl_r;
  logic [HW:0]                 diff;

  assign rdy_o = !vld_r || rdy_i;

  // The trial value dy << BIT has zero low bits, so only the upper slice is compared.
  assign diff = {1'b0, rem_i[REM_W-1:BIT]}
              - {1'b0, {(HW-sdiv_pkg::DVS_W){1'b0}}, dy_i};

  always_comb begin
    rem_nxt = rem_i;
    q_nxt   = q_i;
    q_nxt[BIT] = !diff[HW];
    if (!diff[HW]) begin
      rem_nxt[REM_W-1:BIT] = diff[HW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (rdy_o) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (vld_i && rdy_o) begin
      rem_r  <= rem_nxt;
      q_r    <= q_nxt;
      dy_r   <= dy_i;
      ctrl_r <= ctrl_i;
    end
  end

  assign vld_o  = vld_r;
  assign rem_o  = rem_r;
  assign q_o    = q_r;
  assign dy_o   = dy_r;
  assign ctrl_o = ctrl_r;

endmodule

>>> rtl/core/sdiv_fmt.sv
// Output stage: applies sign, saturation and divide-by-zero, holds the result.
// Depends on sdiv_pkg.
module sdiv_fmt #(
  parameter int Q_W = 31
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              vld_i,
  output logic                              rdy_o,
  input  logic [Q_W-1:0]                    q_i,
  input  sdiv_pkg::ctrl_t                   ctrl_i,
  output logic                              vld_o,
  input  logic                              rdy_i,
  output logic signed [sdiv_pkg::QUO_W-1:0] quotient_o,
  output logic [sdiv_pkg::STS_W-1:0]        status_o
);

  logic                        vld_r;
  logic [sdiv_pkg::QUO_W-1:0]  quo_r, quo_nxt, mag;
  sdiv_pkg::status_t           sts_r;

  assign rdy_o = !vld_r || rdy_i;

  always_comb begin
    if (ctrl_i.status == sdiv_pkg::ST_OVF) begin
      mag = {{(sdiv_pkg::QUO_W-Q_W){1'b0}}, {Q_W{1'b1}}};
    end else begin
      mag = {{(sdiv_pkg::QUO_W-Q_W){1'b0}}, q_i};
    end
    if (ctrl_i.status == sdiv_pkg::ST_DIV0) begin
      quo_nxt = '0;
    end else if (ctrl_i.qneg) begin
      quo_nxt = ~mag + 1'b1;
    end else begin
      quo_nxt = mag;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (rdy_o) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (vld_i && rdy_o) begin
      quo_r <= quo_nxt;
      sts_r <= ctrl_i.status;
    end
  end

  assign vld_o      = vld_r;
  assign quotient_o = quo_r;
  assign status_o   = sts_r;

endmodule

>>> rtl/core/signed_div_64_by_32_saturating.sv
// Signed 64-by-32 saturating divider, fully pipelined restoring division.
// A transfer passes the prep, overflow check, step and output stages in order.
// Throughput: one transfer per cycle while out_ch.ready holds; every stage takes one
// quotient bit or one fixed task, so the rate is set by the subtract in each step stage.
// Reset (rst_n, synchronous, active low) clears only the stage valid bits.
// Depends on sdiv_pkg, sdiv_in_if, sdiv_out_if and the sdiv_* stage modules.
module signed_div_64_by_32_saturating #(
  parameter int QUOT_BITS = 32   // signed quotient range, 8 to 32
) (
  input  logic        clk,
  input  logic        rst_n,
  sdiv_in_if.sink     in_ch,
  sdiv_out_if.source  out_ch
);

  // Magnitude of a non-saturating quotient fits Q_W bits; the remainder never
  // exceeds dy << Q_W, which fits REM_W bits.
  localparam int Q_W   = QUOT_BITS - 1;
  localparam int REM_W = sdiv_pkg::DVS_W + Q_W;
  localparam int NSTEP = Q_W;

  // Front stage outputs.
  logic                        prep_vld, prep_rdy;
  logic [sdiv_pkg::DVD_W-1:0]  prep_nx;
  logic [sdiv_pkg::DVS_W-1:0]  prep_dy;
  sdiv_pkg::ctrl_t             prep_ctrl;

  // Division chain: index 0 is the overflow check output, index k+1 the output
  // of step k. Step k decides quotient bit Q_W-1-k, most significant first.
  logic                        vld_s  [NSTEP+1];
  logic                        rdy_s  [NSTEP+1];
  logic [REM_W-1:0]            rem_s  [NSTEP+1];
  logic [Q_W-1:0]              q_s    [NSTEP+1];
  logic [sdiv_pkg::DVS_W-1:0]  dy_s   [NSTEP+1];
  sdiv_pkg::ctrl_t             ctrl_s [NSTEP+1];

  // Take magnitudes and flag a zero divisor.
  sdiv_prep u_prep (
    .clk        (clk),
    .rst_n      (rst_n),
    .vld_i      (in_ch.valid),
    .rdy_o      (in_ch.ready),
    .dividend_i (in_ch.dividend),
    .divisor_i  (in_ch.divisor),
    .vld_o      (prep_vld),
    .rdy_i      (prep_rdy),
    .nx_o       (prep_nx),
    .dy_o       (prep_dy),
    .ctrl_o     (prep_ctrl)
  );

  // Detect overflow before any step runs; saturated items still flow through
  // the chain so order is kept, and the output stage overrides their quotient.
  sdiv_chk #(
    .Q_W   (Q_W),
    .REM_W (REM_W)
  ) u_chk (
    .clk    (clk),
    .rst_n  (rst_n),
    .vld_i  (prep_vld),
    .rdy_o  (prep_rdy),
    .nx_i   (prep_nx),
    .dy_i   (prep_dy),
    .ctrl_i (prep_ctrl),
    .vld_o  (vld_s[0]),
    .rdy_i  (rdy_s[0]),
    .rem_o  (rem_s[0]),
    .dy_o   (dy_s[0]),
    .ctrl_o (ctrl_s[0])
  );

  // The quotient starts empty; each step fills its bit.
  assign q_s[0] = '0;

  for (genvar k = 0; k < NSTEP; k++) begin : g_step
    sdiv_step #(
      .Q_W   (Q_W),
      .REM_W (REM_W),
      .BIT   (Q_W - 1 - k)
    ) u_step (
      .clk    (clk),
      .rst_n  (rst_n),
      .vld_i  (vld_s[k]),
      .rdy_o  (rdy_s[k]),
      .rem_i  (rem_s[k]),
      .q_i    (q_s[k]),
      .dy_i   (dy_s[k]),
      .ctrl_i (ctrl_s[k]),
      .vld_o  (vld_s[k+1]),
      .rdy_i  (rdy_s[k+1]),
      .rem_o  (rem_s[k+1]),
      .q_o    (q_s[k+1]),
      .dy_o   (dy_s[k+1]),
      .ctrl_o (ctrl_s[k+1])
    );
  end

  // Apply the sign, saturate or zero, and hold the result until its transfer.
  // Each stage advances when it is empty or its successor advances, so bubbles
  // collapse and new input is taken while a finished result waits, until every stage is full.
  sdiv_fmt #(
    .Q_W (Q_W)
  ) u_fmt (
    .clk        (clk),
    .rst_n      (rst_n),
    .vld_i      (vld_s[NSTEP]),
    .rdy_o      (rdy_s[NSTEP]),
    .q_i        (q_s[NSTEP]),
    .ctrl_i     (ctrl_s[NSTEP]),
    .vld_o      (out_ch.valid),
    .rdy_i      (out_ch.ready),
    .quotient_o (out_ch.quotient),
    .status_o   (out_ch.status)
  );

endmodule

>>> sim/testbench.sv
// Self-checking testbench for the signed 64-by-32 saturating divider.
// Drives operands through the input channel and checks every quotient and status
// against an in-bench divider model; depends on sdiv_pkg, sdiv_in_if and sdiv_out_if.
module testbench;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int QB        = 32;      // quotient bits the divider is built with
  localparam int IDLE_PCT  = 34;      // chance in a hundred that a side idles
  localparam int CYCLE_CAP = 200000;  // generous ceiling for the whole run

  // One predicted quotient transfer.
  typedef struct packed {
    logic signed [sdiv_pkg::QUO_W-1:0] quotient;
    sdiv_pkg::status_t                 status;
  } div_result_t;

  logic clk = 1'b0;
  logic rst_n;

  sdiv_in_if  in_ch ();
  sdiv_out_if out_ch ();

  signed_div_64_by_32_saturating #(
    .QUOT_BITS(QB)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #5 clk = ~clk;

  // Quotients predicted for accepted operands, oldest first.
  div_result_t quot_queue[$];
  div_result_t want;
  int          errors = 0;
  int          cycles = 0;
  // When set, the side never idles; used for the back-to-back stretch.
  bit          src_steady  = 1'b0;
  bit          sink_steady = 1'b0;

  // Print one line per mismatch and count it.
  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    errors++;
  endtask

  // Divider model: zero divisor, magnitudes, saturation check against 2^(QB-1) * |divisor|,
  // truncating divide, then the sign from the XOR of the operand signs.
  function automatic div_result_t predict_div(
      input logic signed [sdiv_pkg::DVD_W-1:0] a,
      input logic signed [sdiv_pkg::DVS_W-1:0] b);
    div_result_t r;
    logic [sdiv_pkg::DVD_W-1:0] nx, dy, lim, q;
    logic [sdiv_pkg::DVS_W-1:0] bmag;
    logic                       neg;
    if (b == '0) begin
      r.quotient = '0;
      r.status   = sdiv_pkg::ST_DIV0;
      return r;
    end
    // -2^63 and -2^31 come out exact as unsigned magnitudes.
    nx   = a[sdiv_pkg::DVD_W-1] ? (~a + 64'd1) : a;
    bmag = b[sdiv_pkg::DVS_W-1] ? (~b + 32'd1) : b;
    dy   = {32'd0, bmag};
    lim  = dy << (QB - 1);
    neg  = a[sdiv_pkg::DVD_W-1] ^ b[sdiv_pkg::DVS_W-1];
    if (nx >= lim) begin
      q        = (64'd1 << (QB - 1)) - 64'd1;
      r.status = sdiv_pkg::ST_OVF;
    end else begin
      q        = nx / dy;
      r.status = sdiv_pkg::ST_OK;
    end
    // A zero magnitude negates to zero, so no negative zero appears.
    if (neg) q = ~q + 64'd1;
    r.quotient = q[sdiv_pkg::QUO_W-1:0];
    return r;
  endfunction

  // Send one operand pair: idle for a random gap, hold valid until the
  // transfer, then record the predicted quotient.
  task automatic send_div(input logic signed [sdiv_pkg::DVD_W-1:0] a,
                          input logic signed [sdiv_pkg::DVS_W-1:0] b);
    while (!src_steady && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.dividend <= a;
    in_ch.divisor  <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    quot_queue.push_back(predict_div(a, b));
  endtask

  // Drop valid and hold off until every predicted quotient has come back.
  task automatic wait_for_results();
    in_ch.valid <= 1'b0;
    while (quot_queue.size() != 0) @(posedge clk);
  endtask

  // Random operands, mostly well-formed divisions with in-range quotients,
  // plus boundary hits around saturation, zero divisors and raw noise.
  function automatic void pick_operands(output logic signed [sdiv_pkg::DVD_W-1:0] a,
                                        output logic signed [sdiv_pkg::DVS_W-1:0] b);
    logic [sdiv_pkg::DVD_W-1:0] nx, dy, qm;
    int                         kind;
    kind = $urandom_range(99);
    if (kind < 8) begin
      a = {$urandom, $urandom};
      b = $urandom;
      return;
    end
    if (kind < 12) begin
      a = {$urandom, $urandom} >> $urandom_range(63, 0);
      b = '0;
      return;
    end
    // Divisor magnitude of random width; now and then exactly 2^31.
    if ($urandom_range(99) < 3) dy = 64'h8000_0000;
    else dy = {32'd0, $urandom} >> $urandom_range(31, 1);
    if (dy == 64'd0) dy = 64'd1;
    if (kind < 25) begin
      // Straddle the saturation threshold by up to two either way.
      nx = (dy << (QB - 1)) - 64'd2 + $urandom_range(4, 0);
    end else begin
      qm = {32'd0, $urandom} >> $urandom_range(32, 1);
      nx = qm * dy + ({32'd0, $urandom} % dy);
    end
    if (dy == 64'h8000_0000) b = 32'h8000_0000;
    else b = $urandom_range(1, 0) ? -dy[31:0] : dy[31:0];
    a = $urandom_range(1, 0) ? -nx : nx;
  endfunction

  task automatic test_divide_by_zero();
    send_div(64'sd0, 32'sd0);
    send_div(64'h7FFF_FFFF_FFFF_FFFF, 32'sd0);
    send_div(64'h8000_0000_0000_0000, 32'sd0);
  endtask

  // All four sign combinations, and zero quotients of mixed signs.
  task automatic test_sign_combinations();
    send_div(64'sd7, 32'sd2);
    send_div(-64'sd7, 32'sd2);
    send_div(64'sd7, -32'sd2);
    send_div(-64'sd7, -32'sd2);
    send_div(-64'sd5, 32'sd7);
    send_div(64'sd5, -32'sd7);
  endtask

  // Dividend magnitude exactly at the threshold saturates; one below does not.
  task automatic test_overflow_boundary();
    logic signed [sdiv_pkg::DVD_W-1:0] lim;
    lim = 64'sd3 <<< (QB - 1);
    send_div(lim, 32'sd3);
    send_div(lim - 64'sd1, 32'sd3);
    send_div(-lim, 32'sd3);
    send_div(-(lim - 64'sd1), 32'sd3);
    send_div(lim, -32'sd3);
    send_div(-(lim - 64'sd1), -32'sd3);
  endtask

  // Most negative and most positive operands.
  task automatic test_operand_extremes();
    send_div(64'h8000_0000_0000_0000, -32'sd1);
    send_div(64'h8000_0000_0000_0000, 32'h8000_0000);
    send_div(64'h7FFF_FFFF_FFFF_FFFF, 32'h7FFF_FFFF);
    send_div(64'h8000_0000_0000_0000, 32'sd1);
    send_div(64'hC000_0000_0000_0000, 32'h8000_0000);
    send_div(64'h3FFF_FFFF_FFFF_FFFF, 32'h8000_0000);
  endtask

  // Random divisions with both sides idling at random.
  task automatic test_random_mixed(input int count);
    logic signed [sdiv_pkg::DVD_W-1:0] a;
    logic signed [sdiv_pkg::DVS_W-1:0] b;
    repeat (count) begin
      pick_operands(a, b);
      send_div(a, b);
    end
  endtask

  // Random divisions back to back, with neither side ever idling.
  task automatic test_random_steady(input int count);
    logic signed [sdiv_pkg::DVD_W-1:0] a;
    logic signed [sdiv_pkg::DVS_W-1:0] b;
    src_steady  = 1'b1;
    sink_steady = 1'b1;
    repeat (count) begin
      pick_operands(a, b);
      send_div(a, b);
    end
    src_steady  = 1'b0;
    sink_steady = 1'b0;
  endtask

  // Check each result transfer against the oldest prediction, then pick the
  // next cycle's ready. Values here are the ones held before the edge.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (quot_queue.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending: quotient %0d status %0d",
                                  out_ch.quotient, out_ch.status));
      end else begin
        want = quot_queue.pop_front();
        if (out_ch.quotient !== want.quotient)
          report_mismatch($sformatf("quotient %0d, predicted %0d",
                                    out_ch.quotient, want.quotient));
        if (out_ch.status !== want.status)
          report_mismatch($sformatf("status %0d, predicted %s",
                                    out_ch.status, want.status.name()));
      end
    end
    out_ch.ready <= sink_steady || ($urandom_range(99) >= IDLE_PCT);
  end

  // Timeout guard: fail if the run ever stalls past the cap.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("testbench failed");
      $finish;
    end
  end

  initial begin
    // Known values on every input from time zero; hold reset asserted before the first test.
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.dividend = '0;
    in_ch.divisor  = '0;
    out_ch.ready   = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    test_divide_by_zero();
    test_sign_combinations();
    test_overflow_boundary();
    test_operand_extremes();
    // Let the pipeline empty completely before the random traffic.
    wait_for_results();
    test_random_mixed(400);
    wait_for_results();
    test_random_steady(230);
    wait_for_results();

    // Give any stray result time to show up after the last expected one.
    repeat (QB + 8) @(posedge clk);
    if (errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
